// ===== rtl/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared constants, transaction payload types and controller interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package lpr_pkg;

   localparam int FRAMES_MAX_DEFAULT = 8;
   localparam int PAGE_BITS_DEFAULT  = 16;

   localparam int CSR_W       = 4;
   localparam int PAGE_W      = 16;
   localparam int FRAME_IDX_W = 3;
   localparam int COUNT_W     = 32;

   localparam logic [CSR_W-1:0]   CSR_RESET = CSR_W'(3);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic              start_of_string;
      logic [PAGE_W-1:0] page;
   } req_type;

   typedef struct packed {
      logic                   hit;
      logic [FRAME_IDX_W-1:0] frame_index;
      logic                   evicted_valid;
      logic [PAGE_W-1:0]      evicted_page;
      logic [COUNT_W-1:0]     hit_count;
      logic [COUNT_W-1:0]     fault_count;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic lookup;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic empty;
      logic scan_done;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/lpr_datapath.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement datapath
// Frame table, recency ranks, counters, victim scan and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_datapath #(
   parameter int FRAMES_MAX = lpr_pkg::FRAMES_MAX_DEFAULT,
   parameter int PAGE_BITS  = lpr_pkg::PAGE_BITS_DEFAULT
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           csr_valid,
   input  wire  [lpr_pkg::CSR_W-1:0]     csr_data,
   input  lpr_pkg::req_type              req_data,
   input  lpr_pkg::cmd_type              cmd,
   output lpr_pkg::status_type           status,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output lpr_pkg::rsp_type              rsp_data
);

   localparam int IDX_W = (FRAMES_MAX > 1) ? $clog2(FRAMES_MAX) : 1;
   localparam int CNT_W = $clog2(FRAMES_MAX + 1);
   localparam int AGE_W = IDX_W;
   localparam int OLD_W = AGE_W + 1;
   localparam logic [AGE_W-1:0] AGE_SAT = AGE_W'(FRAMES_MAX - 1);
   localparam logic [OLD_W-1:0] AGE_FILL = OLD_W'(FRAMES_MAX);

   logic [lpr_pkg::CSR_W-1:0]   csr_ff;
   logic [PAGE_BITS-1:0]        frame_page_ff [FRAMES_MAX];
   logic [FRAMES_MAX-1:0]       frame_valid_ff;
   logic [AGE_W-1:0]            rank_ff [FRAMES_MAX];
   logic [lpr_pkg::COUNT_W-1:0] hits_ff;
   logic [lpr_pkg::COUNT_W-1:0] faults_ff;
   logic                        rsp_valid_ff;
   lpr_pkg::rsp_type            rsp_data_ff;

   logic [PAGE_BITS-1:0]        page_ff;
   logic                        hit_ff;
   logic                        evict_ff;
   logic [IDX_W-1:0]            target_ff;
   logic [OLD_W-1:0]            old_age_ff;
   logic [CNT_W-1:0]            scan_ff;

   logic [CNT_W-1:0]            active_n;
   logic [FRAMES_MAX-1:0]       active;
   logic [FRAMES_MAX-1:0]       match;
   logic [FRAMES_MAX-1:0]       empty;
   logic [IDX_W-1:0]            match_idx;
   logic [IDX_W-1:0]            empty_idx;
   logic [AGE_W-1:0]            scan_age;
   logic [lpr_pkg::COUNT_W-1:0] hits_in;
   logic [lpr_pkg::COUNT_W-1:0] faults_in;
   logic                        out_free;

   always_comb begin
      priority if (csr_ff == '0) begin
         active_n = CNT_W'(1);
      end else if (int'(csr_ff) > FRAMES_MAX) begin
         active_n = CNT_W'(FRAMES_MAX);
      end else begin
         active_n = CNT_W'(csr_ff);
      end
   end

   always_comb begin
      match_idx = '0;
      empty_idx = '0;
      for (int f = FRAMES_MAX - 1; f >= 0; f--) begin
         active[f] = (f < int'(active_n));
         match[f]  = active[f] && frame_valid_ff[f] && (frame_page_ff[f] == page_ff);
         empty[f]  = active[f] && !frame_valid_ff[f];
         if (match[f]) begin
            match_idx = IDX_W'(f);
         end
         if (empty[f]) begin
            empty_idx = IDX_W'(f);
         end
      end
   end

   assign scan_age  = rank_ff[scan_ff[IDX_W-1:0]];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign hits_in   = (hit_ff && hits_ff != lpr_pkg::COUNT_MAX) ? hits_ff + 1'b1 : hits_ff;
   assign faults_in = (!hit_ff && faults_ff != lpr_pkg::COUNT_MAX) ?
                      faults_ff + 1'b1 : faults_ff;

   always_comb begin
      status.hit       = |match;
      status.empty     = |empty;
      status.scan_done = (scan_ff >= active_n);
      status.out_free  = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff         <= lpr_pkg::CSR_RESET;
         frame_valid_ff <= '0;
         hits_ff        <= '0;
         faults_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int f = 0; f < FRAMES_MAX; f++) begin
            frame_page_ff[f] <= '0;
            rank_ff[f]       <= '0;
         end
      end else begin
         if (csr_valid) begin
            csr_ff <= csr_data;
         end
         if (rsp_valid_ff && rsp_ready && !cmd.commit) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.load && req_data.start_of_string) begin
            frame_valid_ff <= '0;
            hits_ff        <= '0;
            faults_ff      <= '0;
            for (int f = 0; f < FRAMES_MAX; f++) begin
               frame_page_ff[f] <= '0;
               rank_ff[f]       <= '0;
            end
         end
         if (cmd.commit) begin
            for (int f = 0; f < FRAMES_MAX; f++) begin
               if (IDX_W'(f) == target_ff) begin
                  rank_ff[f] <= '0;
               end else if (active[f] && frame_valid_ff[f] &&
                            ({1'b0, rank_ff[f]} < old_age_ff) && (rank_ff[f] < AGE_SAT)) begin
                  rank_ff[f] <= rank_ff[f] + 1'b1;
               end
            end
            if (!hit_ff) begin
               frame_page_ff[target_ff]  <= page_ff;
               frame_valid_ff[target_ff] <= 1'b1;
            end
            hits_ff      <= hits_in;
            faults_ff    <= faults_in;
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         page_ff <= PAGE_BITS'(req_data.page);
      end
      if (cmd.lookup) begin
         hit_ff   <= status.hit;
         evict_ff <= !status.hit && !status.empty;
         scan_ff  <= CNT_W'(1);
         priority if (status.hit) begin
            target_ff  <= match_idx;
            old_age_ff <= {1'b0, rank_ff[match_idx]};
         end else if (status.empty) begin
            target_ff  <= empty_idx;
            old_age_ff <= AGE_FILL;
         end else begin
            target_ff  <= '0;
            old_age_ff <= {1'b0, rank_ff[0]};
         end
      end
      if (cmd.scan && !status.scan_done) begin
         if ({1'b0, scan_age} > old_age_ff) begin
            target_ff  <= scan_ff[IDX_W-1:0];
            old_age_ff <= {1'b0, scan_age};
         end
         scan_ff <= scan_ff + 1'b1;
      end
      if (cmd.commit) begin
         rsp_data_ff.hit           <= hit_ff;
         rsp_data_ff.frame_index   <= lpr_pkg::FRAME_IDX_W'(target_ff);
         rsp_data_ff.evicted_valid <= evict_ff;
         rsp_data_ff.evicted_page  <= evict_ff ?
                                      lpr_pkg::PAGE_W'(frame_page_ff[target_ff]) : '0;
         rsp_data_ff.hit_count     <= hits_in;
         rsp_data_ff.fault_count   <= faults_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/lpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement controller
// Sequences lookup, victim scan and table update for one reference.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   output lpr_pkg::cmd_type     cmd,
   input  lpr_pkg::status_type  status
);

   typedef enum logic [1:0] {
      IDLE,
      LOOKUP,
      SCAN,
      TOUCH
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  state_ff     <= LOOKUP;
                  req_ready_ff <= 1'b0;
               end
            end
            LOOKUP: begin
               if (status.hit || status.empty) begin
                  state_ff <= TOUCH;
               end else begin
                  state_ff <= SCAN;
               end
            end
            SCAN: begin
               if (status.scan_done) begin
                  state_ff <= TOUCH;
               end
            end
            TOUCH: begin
               if (status.out_free) begin
                  state_ff     <= IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= IDLE;
               req_ready_ff <= 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      cmd.load   = (state_ff == IDLE) && req_valid;
      cmd.lookup = (state_ff == LOOKUP);
      cmd.scan   = (state_ff == SCAN);
      cmd.commit = (state_ff == TOUCH) && status.out_free;
   end

   assign req_ready = req_ready_ff;

endmodule

`default_nettype wire

// ===== rtl/lru_page_replacement.sv =====
// A hit or a fill of an empty frame passes through the LOOKUP and TOUCH states, and rsp_valid
// is registered at the commit in TOUCH; an eviction first walks the active frames in SCAN.
// A new reference is accepted only once the current one leaves TOUCH, which waits while the
// result register is full; the single victim-scan comparator steps through one frame a cycle.
// Reset clears all frames, ranks and counters and sets the frame count register to three.
// ----------------------------------------------------------------------------
// LRU page replacement unit
// Looks each page reference up in the frame table and on a fault fills an empty
// frame or else replaces the least recently used one, reporting hit and fault counts.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement #(
   parameter int FRAMES_MAX = lpr_pkg::FRAMES_MAX_DEFAULT,
   parameter int PAGE_BITS  = lpr_pkg::PAGE_BITS_DEFAULT
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire  [lpr_pkg::CSR_W-1:0]  csr_data,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  lpr_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output lpr_pkg::rsp_type           rsp_data
);

   lpr_pkg::cmd_type    cmd;
   lpr_pkg::status_type status;

   assign csr_ready = 1'b1;

   lpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   lpr_datapath #(
      .FRAMES_MAX (FRAMES_MAX),
      .PAGE_BITS  (PAGE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
